// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top-level RTL file for its concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk and disabled while rst_n is low.
`define WFE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk and disabled while rst_n is low.
`define WFE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/wfe_pkg.sv -----
// Package with the types, codes and widths shared by the frame encoder modules.
`default_nettype none
package wfe_pkg;

  localparam int unsigned LEN_W   = 63;
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned CAP_W   = 32;
  localparam int unsigned IN_DW   = 112;
  localparam int unsigned OUT_DW  = 72;

  localparam logic [CAP_W-1:0] CAP_RESET = '1;

  // Byte sources for one output transaction.
  localparam logic [2:0] SEL_FIRST = 3'd0;
  localparam logic [2:0] SEL_LEN   = 3'd1;
  localparam logic [2:0] SEL_EXT   = 3'd2;
  localparam logic [2:0] SEL_KEY   = 3'd3;
  localparam logic [2:0] SEL_ERR   = 3'd4;

  // Extended length forms.
  localparam logic [1:0] EXT_NONE = 2'd0;
  localparam logic [1:0] EXT_16   = 2'd1;
  localparam logic [1:0] EXT_64   = 2'd2;

  localparam logic [7:0] CODE_16  = 8'h7e;
  localparam logic [7:0] CODE_64  = 8'h7f;
  localparam logic [7:0] FLAG_BIT = 8'h80;

  typedef struct packed {
    logic       hdr_load;
    logic       pay_load;
    logic       calc;
    logic       start;
    logic       emit;
    logic [2:0] sel;
    logic [2:0] idx;
    logic       last;
  } wfe_cmd_t;

  typedef struct packed {
    logic       out_free;
    logic       overflow;
    logic [1:0] ext_kind;
    logic       masked;
    logic       len_zero;
  } wfe_stat_t;

endpackage
`default_nettype wire

// ----- rtl/wfe_ctrl.sv -----
// Controller state machine that sequences header bytes and admits input items.
`default_nettype none
module wfe_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  input  wire logic              in_tuser,
  output logic                   in_tready,
  input  wire wfe_pkg::wfe_stat_t stat,
  output wfe_pkg::wfe_cmd_t      cmd
);
  import wfe_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CALC  = 3'd1;
  localparam logic [2:0] ST_CHECK = 3'd2;
  localparam logic [2:0] ST_LEN   = 3'd3;
  localparam logic [2:0] ST_EXT   = 3'd4;
  localparam logic [2:0] ST_KEY   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       in_fire;

  assign in_tready = (state_r == ST_IDLE) && stat.out_free;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd          = '0;
    cmd.hdr_load = in_fire && !in_tuser;
    cmd.pay_load = in_fire && in_tuser;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && !in_tuser) begin
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.overflow) begin
            cmd.sel   = SEL_ERR;
            cmd.last  = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            cmd.sel   = SEL_FIRST;
            cmd.start = 1'b1;
            state_nxt = ST_LEN;
          end
        end
      end
      ST_LEN: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = SEL_LEN;
          // An empty payload without key ends the frame on the length byte.
          cmd.last = stat.len_zero && !stat.masked;
          if (stat.ext_kind == EXT_16) begin
            cnt_nxt   = 3'd1;
            state_nxt = ST_EXT;
          end else if (stat.ext_kind == EXT_64) begin
            cnt_nxt   = 3'd7;
            state_nxt = ST_EXT;
          end else if (stat.masked) begin
            cnt_nxt   = 3'd0;
            state_nxt = ST_KEY;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_EXT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = SEL_EXT;
          cmd.idx  = cnt_r;
          if (cnt_r == 3'd0) begin
            state_nxt = stat.masked ? ST_KEY : ST_IDLE;
          end else begin
            cnt_nxt = cnt_r - 3'd1;
          end
        end
      end
      ST_KEY: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          cmd.sel  = SEL_KEY;
          cmd.idx  = cnt_r;
          cmd.last = (cnt_r == 3'd3) && stat.len_zero;
          if (cnt_r == 3'd3) begin
            state_nxt = ST_IDLE;
          end else begin
            cnt_nxt = cnt_r + 3'd1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/wfe_datapath.sv -----
// Datapath: header fields, frame total, payload masking and the output register.
`default_nettype none
module wfe_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [wfe_pkg::IN_DW-1:0]   in_tdata,
  input  wire logic                        cfg_we,
  input  wire logic [wfe_pkg::CAP_W-1:0]   cfg_wdata,
  input  wire wfe_pkg::wfe_cmd_t           cmd,
  output wfe_pkg::wfe_stat_t               stat,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [wfe_pkg::OUT_DW-1:0]       out_tdata,
  output logic                             out_tlast,
  output logic                             out_tuser
);
  import wfe_pkg::*;

  logic [3:0]       in_opcode;
  logic             in_fin;
  logic             in_mask;
  logic [KEY_W-1:0] in_key;
  logic [LEN_W-1:0] in_len;
  logic [7:0]       in_byte;

  logic [CAP_W-1:0] cap_r;
  logic [3:0]       opcode_r;
  logic             fin_r;
  logic             hmask_r;
  logic [KEY_W-1:0] key_r;
  logic [LEN_W-1:0] len_r;
  logic [1:0]       ext_r;
  logic [LEN_W-1:0] total_r, total_nxt;
  logic [LEN_W-1:0] remain_r, remain_nxt;
  logic [1:0]       kidx_r, kidx_nxt;
  logic             mask_on_r, mask_on_nxt;

  logic             ovalid_r, ovalid_nxt;
  logic [7:0]       obyte_r, obyte_nxt;
  logic             olast_r, olast_nxt;
  logic             oerr_r, oerr_nxt;
  logic [LEN_W-1:0] ototal_r, ototal_nxt;

  logic [3:0]       hdr_bytes;
  logic [LEN_W:0]   sum;
  logic [LEN_W:0]   len_wide;
  logic [7:0]       hdr_byte;
  logic [7:0]       key_byte;
  logic [1:0]       key_sel;
  logic             pay_live;

  assign in_opcode = in_tdata[3:0];
  assign in_fin    = in_tdata[4];
  assign in_mask   = in_tdata[5];
  assign in_key    = in_tdata[37:6];
  assign in_len    = in_tdata[100:38];
  assign in_byte   = in_tdata[108:101];

  assign stat.out_free = !ovalid_r || out_tready;
  assign stat.overflow = (|total_r[LEN_W-1:CAP_W]) || (total_r[CAP_W-1:0] > cap_r);
  assign stat.ext_kind = ext_r;
  assign stat.masked   = hmask_r;
  assign stat.len_zero = (len_r == '0);

  always_comb begin
    hdr_bytes = 4'd2 + (hmask_r ? 4'd4 : 4'd0);
    if (ext_r == EXT_16) begin
      hdr_bytes = hdr_bytes + 4'd2;
    end else if (ext_r == EXT_64) begin
      hdr_bytes = hdr_bytes + 4'd8;
    end
    sum = {1'b0, len_r} + {{(LEN_W - 3){1'b0}}, hdr_bytes};
  end

  // The eight-byte length form reads a full 64-bit word whose top bit is zero.
  assign len_wide = {1'b0, len_r};

  // The key byte for a header slot or for the next payload byte; key byte 0 sits on top.
  assign key_sel  = (cmd.emit && cmd.sel == SEL_KEY) ? cmd.idx[1:0] : kidx_r;
  assign key_byte = key_r[8 * (3 - key_sel) +: 8];

  always_comb begin
    case (cmd.sel)
      SEL_FIRST: hdr_byte = {fin_r, 3'b000, opcode_r};
      SEL_LEN: begin
        case (ext_r)
          EXT_16:  hdr_byte = CODE_16;
          EXT_64:  hdr_byte = CODE_64;
          default: hdr_byte = {1'b0, len_r[6:0]};
        endcase
        if (hmask_r) begin
          hdr_byte = hdr_byte | FLAG_BIT;
        end
      end
      SEL_EXT: hdr_byte = len_wide[8 * cmd.idx +: 8];
      SEL_KEY: hdr_byte = key_byte;
      default: hdr_byte = 8'h00;
    endcase
  end

  assign pay_live = cmd.pay_load && (remain_r != '0);

  always_comb begin
    total_nxt   = total_r;
    remain_nxt  = remain_r;
    kidx_nxt    = kidx_r;
    mask_on_nxt = mask_on_r;
    ovalid_nxt  = ovalid_r && !out_tready;
    obyte_nxt   = obyte_r;
    olast_nxt   = olast_r;
    oerr_nxt    = oerr_r;
    ototal_nxt  = ototal_r;
    if (cmd.calc) begin
      // A total that runs past 63 bits saturates.
      total_nxt = sum[LEN_W] ? '1 : sum[LEN_W-1:0];
    end
    if (cmd.start) begin
      remain_nxt  = len_r;
      kidx_nxt    = '0;
      mask_on_nxt = hmask_r;
    end
    if (cmd.emit) begin
      ovalid_nxt = 1'b1;
      obyte_nxt  = hdr_byte;
      olast_nxt  = cmd.last;
      oerr_nxt   = (cmd.sel == SEL_ERR);
      ototal_nxt = total_r;
      if (cmd.sel == SEL_ERR) begin
        remain_nxt  = '0;
        kidx_nxt    = '0;
        mask_on_nxt = 1'b0;
      end
    end
    if (pay_live) begin
      ovalid_nxt = 1'b1;
      obyte_nxt  = mask_on_r ? (in_byte ^ key_byte) : in_byte;
      olast_nxt  = (remain_r == {{(LEN_W - 1){1'b0}}, 1'b1});
      oerr_nxt   = 1'b0;
      ototal_nxt = total_r;
      remain_nxt = remain_r - {{(LEN_W - 1){1'b0}}, 1'b1};
      kidx_nxt   = kidx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r     <= CAP_RESET;
      total_r   <= '0;
      remain_r  <= '0;
      kidx_r    <= '0;
      mask_on_r <= 1'b0;
      ovalid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      total_r   <= total_nxt;
      remain_r  <= remain_nxt;
      kidx_r    <= kidx_nxt;
      mask_on_r <= mask_on_nxt;
      ovalid_r  <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    obyte_r  <= obyte_nxt;
    olast_r  <= olast_nxt;
    oerr_r   <= oerr_nxt;
    ototal_r <= ototal_nxt;
    if (cmd.hdr_load) begin
      opcode_r <= in_opcode;
      fin_r    <= in_fin;
      hmask_r  <= in_mask;
      key_r    <= in_key;
      len_r    <= in_len;
      if (in_len < LEN_W'(126)) begin
        ext_r <= EXT_NONE;
      end else if (in_len <= LEN_W'(65535)) begin
        ext_r <= EXT_16;
      end else begin
        ext_r <= EXT_64;
      end
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {1'b0, ototal_r, obyte_r};
  assign out_tlast  = olast_r;
  assign out_tuser  = oerr_r;

endmodule
`default_nettype wire

// ----- rtl/websocket_frame_encoder_top.sv -----
// Top level of the WebSocket frame encoder: controller, datapath and checks.
//
// Channel  Direction  Content
// in_      slave      header descriptor or payload byte, kind in tuser
// out_     master     framed byte with frame total, error flag in tuser
// cfg_     write      buffer capacity in bytes
//
// A payload byte of a live frame goes into the output register as it is accepted;
// a stray one is dropped. A header's frame total is formed in the calc state and
// checked in the check state; from there its 2 to 14 header bytes go out in turn,
// and the next item waits. An overflowing frame gives only its error transaction.
// A stalled output holds the sequencer; no input is taken until the register drains.
// Reset is synchronous; it restores the full capacity and clears the frame state.
`default_nettype none
module websocket_frame_encoder_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  // [3:0] opcode, [4] fin_flag, [5] mask_enable, [37:6] mask_key,
  // [100:38] payload_len, [108:101] payload_byte, [111:109] zero
  input  wire logic [wfe_pkg::IN_DW-1:0]   in_tdata,
  // [0] func
  input  wire logic                        in_tuser,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  // [7:0] out_byte, [70:8] frame_total, [71] zero
  output logic [wfe_pkg::OUT_DW-1:0]       out_tdata,
  output logic                             out_tlast,
  // [0] overflow_error
  output logic                             out_tuser,
  input  wire logic                        cfg_we,
  input  wire logic [wfe_pkg::CAP_W-1:0]   cfg_wdata
);
  import wfe_pkg::*;

  wfe_cmd_t  cmd;
  wfe_stat_t stat;

  wfe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  wfe_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

`include "assert_macros.svh"

  `WFE_ASSERT_NOW(a_ready_needs_slot, in_tready, !out_tvalid || out_tready, "output full")
  `WFE_ASSERT_NOW(a_emit_needs_slot, cmd.emit, stat.out_free, "emit into full output")
  `WFE_ASSERT_NOW(a_error_is_last, out_tvalid && out_tuser, out_tlast, "error not last")
  `WFE_ASSERT_NEXT(a_header_busy, in_tvalid && in_tready && !in_tuser, !in_tready, "header busy")

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// Self-checking testbench for the WebSocket frame encoder top level.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wfe_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned IDLE_LIMIT    = 4000;
  localparam int unsigned ITEM_TARGET   = 410;
  localparam bit [62:0]   LEN_MAX       = 63'h7FFF_FFFF_FFFF_FFFF;

  typedef enum bit {FUNC_HDR = 1'b0, FUNC_PAY = 1'b1} item_kind_t;

  typedef struct {
    item_kind_t kind;
    bit [3:0]   opcode;
    bit         fin;
    bit         masked;
    bit [31:0]  mask_word;
    bit [62:0]  length;
    bit [7:0]   pay_byte;
  } ws_item_t;

  typedef struct {
    bit [7:0]  data;
    bit        last;
    bit        overflow;
    bit [62:0] total;
  } frame_byte_t;

  // Tracks the framing state and holds the bytes the encoder still owes.
  class frame_checker_t;
    bit [31:0]   capacity;
    bit [62:0]   pay_left;
    bit [31:0]   frame_key;
    bit [1:0]    key_pos;
    bit          mask_on;
    bit [62:0]   held_total;
    frame_byte_t due_bytes[$];
    int unsigned errors;

    function new();
      capacity   = CAP_RESET;
      pay_left   = '0;
      frame_key  = '0;
      key_pos    = '0;
      mask_on    = 1'b0;
      held_total = '0;
      errors     = 0;
    endfunction

    function int unsigned outstanding();
      return due_bytes.size();
    endfunction

    function void owe(bit [7:0] data, bit last, bit overflow, bit [62:0] total);
      frame_byte_t fb;
      fb.data     = data;
      fb.last     = last;
      fb.overflow = overflow;
      fb.total    = total;
      due_bytes.push_back(fb);
    endfunction

    function void absorb_item(ws_item_t it);
      int unsigned ext;
      int unsigned n;
      bit [7:0]    code;
      bit [7:0]    hdr[14];
      bit [63:0]   wide;
      bit [62:0]   total;
      bit [7:0]    b;
      if (it.kind == FUNC_HDR) begin
        if (it.length < 63'd126) begin
          ext  = 0;
          code = it.length[7:0];
        end else if (it.length <= 63'hFFFF) begin
          ext  = 2;
          code = CODE_16;
        end else begin
          ext  = 8;
          code = CODE_64;
        end
        wide = {1'b0, it.length} + 64'(2 + ext + (it.masked ? 4 : 0));
        total = wide[63] ? LEN_MAX : wide[62:0];
        held_total = total;
        if (total > {31'b0, capacity}) begin
          pay_left = '0;
          mask_on  = 1'b0;
          key_pos  = '0;
          owe(8'h00, 1'b1, 1'b1, total);
          return;
        end
        n = 0;
        hdr[n] = {it.fin, 3'b000, it.opcode};
        n++;
        hdr[n] = code | (it.masked ? FLAG_BIT : 8'h00);
        n++;
        for (int k = int'(ext) - 1; k >= 0; k--) begin
          hdr[n] = 8'(it.length >> (8 * k));
          n++;
        end
        if (it.masked) begin
          for (int k = 3; k >= 0; k--) begin
            hdr[n] = 8'(it.mask_word >> (8 * k));
            n++;
          end
        end
        for (int k = 0; k < int'(n); k++) begin
          owe(hdr[k], (k == int'(n) - 1) && (it.length == 0), 1'b0, total);
        end
        pay_left  = it.length;
        frame_key = it.mask_word;
        key_pos   = '0;
        mask_on   = it.masked;
      end else if (pay_left != 0) begin
        b = it.pay_byte;
        if (mask_on) b ^= 8'(frame_key >> (24 - 8 * key_pos));
        owe(b, pay_left == 1, 1'b0, held_total);
        pay_left--;
        key_pos++;
      end
    endfunction

    function void report(string field, bit [63:0] want, bit [63:0] got);
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    endfunction

    function void check_byte(bit [7:0] data, bit last, bit overflow, bit [62:0] total);
      frame_byte_t fb;
      if (due_bytes.size() == 0) begin
        errors++;
        $display("%0t: unexpected output transaction, byte 0x%0h", $time, data);
        return;
      end
      fb = due_bytes.pop_front();
      if (fb.data != data) report("out_byte", fb.data, data);
      if (fb.last != last) report("last_of_frame", fb.last, last);
      if (fb.overflow != overflow) report("overflow_error", fb.overflow, overflow);
      if (fb.total != total) report("frame_total", fb.total, total);
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [IN_DW-1:0]    in_tdata = '0;
  logic                in_tuser = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b1;
  logic [OUT_DW-1:0]   out_tdata;
  logic                out_tlast;
  logic                out_tuser;
  logic                cfg_we = 1'b0;
  logic [CAP_W-1:0]    cfg_wdata = '0;

  frame_checker_t checker_h = new();
  int unsigned  items_sent = 0;
  int unsigned  hold_len = 0;
  bit           quiet = 1'b0;
  int unsigned  idle_cycles = 0;

  websocket_frame_encoder_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Output side: short random stalls, or one long hold-off when asked for.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_len != 0) begin
        out_tready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
        out_tready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      checker_h.check_byte(out_tdata[7:0], out_tlast, out_tuser, out_tdata[70:8]);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("[websocket_frame_encoder_top] ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic ws_item_t random_item(item_kind_t kind);
    ws_item_t it;
    it.kind      = kind;
    it.opcode    = 4'($urandom);
    it.fin       = 1'($urandom);
    it.masked    = 1'($urandom);
    it.mask_word = $urandom;
    it.length    = 63'({$urandom, $urandom});
    it.pay_byte  = 8'($urandom);
    return it;
  endfunction

  function automatic ws_item_t header(bit [3:0] opcode, bit fin, bit masked,
                                      bit [31:0] mask_word, bit [62:0] length);
    ws_item_t it;
    it           = random_item(FUNC_HDR);
    it.opcode    = opcode;
    it.fin       = fin;
    it.masked    = masked;
    it.mask_word = mask_word;
    it.length    = length;
    return it;
  endfunction

  task automatic push_item(ws_item_t it);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.kind;
    in_tdata  <= {3'b000, it.pay_byte, it.length, it.mask_word, it.masked, it.fin,
                  it.opcode};
    do @(posedge clk); while (!in_tready);
    checker_h.absorb_item(it);
    items_sent++;
  endtask

  task automatic push_payload(bit [7:0] value);
    ws_item_t it;
    it          = random_item(FUNC_PAY);
    it.pay_byte = value;
    push_item(it);
  endtask

  // Stops offering input until every owed byte has come out.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (checker_h.outstanding() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(bit [31:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    checker_h.capacity = value;
    cfg_we <= 1'b0;
  endtask

  // One frame with random content; sometimes cut short, sometimes with stray bytes.
  task automatic random_frame();
    ws_item_t    h;
    int unsigned pick;
    int unsigned n;
    h    = random_item(FUNC_HDR);
    pick = $urandom_range(0, 19);
    if (pick < 12) h.length = 63'($urandom_range(0, 24));
    else if (pick < 15) h.length = 63'($urandom_range(120, 131));
    else if (pick < 18) h.length = 63'($urandom_range(65530, 65540));
    else h.length = 63'({$urandom, $urandom}) >> $urandom_range(0, 40);
    if ($urandom_range(0, 9) == 0) push_payload(8'($urandom));
    push_item(h);
    if (h.length <= 24) begin
      n = int'(h.length);
      if ($urandom_range(0, 7) == 0) n = $urandom_range(0, n);
    end else begin
      n = $urandom_range(0, 6);
    end
    repeat (n) push_payload(8'($urandom));
    if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 2)) push_payload(8'($urandom));
    if ($urandom_range(0, 11) == 0) wait_drained();
  endtask

  task automatic run_frames(int unsigned upto);
    while (items_sent < upto) random_frame();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset capacity.
    push_item(header(4'hF, 1'b1, 1'b0, 32'h0, 63'd0));
    push_item(header(4'h0, 1'b0, 1'b1, 32'hA5C3_0F81, 63'd3));
    push_payload(8'h00);
    push_payload(8'hFF);
    push_payload(8'h5A);
    push_payload(8'h77);
    push_item(header(4'h1, 1'b1, 1'b0, 32'h0, 63'd125));
    push_payload(8'hFF);
    push_payload(8'h00);
    push_item(header(4'h2, 1'b0, 1'b1, 32'hFFFF_FFFF, 63'd126));
    push_payload(8'h3C);
    push_item(header(4'h8, 1'b1, 1'b0, 32'h0, 63'd65535));
    push_payload(8'h81);
    push_item(header(4'h9, 1'b1, 1'b1, 32'h0102_0408, 63'd65536));
    push_payload(8'hC3);
    push_item(header(4'hA, 1'b0, 1'b1, 32'h1234_5678, LEN_MAX));
    push_payload(8'h42);
    push_item(header(4'h3, 1'b1, 1'b0, 32'h0, 63'hFFFF_FFF5));
    push_payload(8'hE7);
    push_item(header(4'h4, 1'b0, 1'b0, 32'h0, 63'hFFFF_FFF6));
    push_payload(8'h18);

    // Nothing fits at zero capacity.
    write_capacity(32'h0);
    run_frames(items_sent + 15);

    // Small capacity, with a long receiver hold-off while input keeps coming.
    write_capacity(32'd24);
    hold_len = 250;
    run_frames(items_sent + 75);

    write_capacity(32'hFFFF_FFFF);
    run_frames(items_sent + 75);

    write_capacity($urandom_range(2, 60));
    run_frames(items_sent + 70);

    write_capacity($urandom);
    run_frames(items_sent + 70);

    // Closing stretch with no idling on either side.
    write_capacity(32'hFFFF_FFFF);
    quiet = 1'b1;
    run_frames(ITEM_TARGET);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (checker_h.errors == 0 && checker_h.outstanding() == 0) begin
      $display("[websocket_frame_encoder_top] OK");
    end else begin
      $display("[websocket_frame_encoder_top] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- websocket_frame_encoder_top.f -----
+incdir+rtl
rtl/wfe_pkg.sv
rtl/wfe_ctrl.sv
rtl/wfe_datapath.sv
rtl/websocket_frame_encoder_top.sv
tb/tb.sv
